// ===== design/lcg_pkg.sv =====
package lcg_pkg;

    // default sizes for the top-level parameters
    localparam int TIME_BITS_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int MAX_STOPS  = 8;
    localparam int COUNT_BITS = 4;
    localparam int NUM_PAIRS  = 4;
    localparam int PAIR_BITS  = 64;
    localparam int STOP_BITS  = 32;
    localparam int CH_BITS    = 8;
    localparam int NUM_CH     = 4;
    localparam int IDX_BITS   = 3;
    localparam int STOP_IDX_BITS = 4;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_COUNT = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_PAIR0 = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_PAIR1 = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_PAIR2 = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_PAIR3 = 3'd4;

    typedef struct packed {
        logic [COUNT_BITS-1:0]                count;
        logic [NUM_PAIRS-1:0][PAIR_BITS-1:0] pair;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic [CH_BITS-1:0] alpha;
    } res_t;

endpackage

// ===== design/lcg_fifo.sv =====
module lcg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/lcg_front.sv =====
module lcg_front #(
    parameter int TIME_BITS     = lcg_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = lcg_pkg::FRACTION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [TIME_BITS-1:0]   life_elapsed,
    input  logic [TIME_BITS-1:0]   life_total,
    output logic                   q_push,
    input  logic                   q_full,
    output logic [FRACTION_BITS:0] q_frac
);

    localparam int TB = TIME_BITS;
    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    // stage 0 captures the item, stages 1..FB each resolve one quotient bit
    logic          valid_reg [FB + 1];
    logic          sat_reg   [FB + 1];
    logic [TB-1:0] rem_reg   [FB + 1];
    logic [TB-1:0] total_reg [FB + 1];
    logic [FB-1:0] quo_reg   [FB + 1];

    logic [TB:0]   trial     [FB + 1];
    logic          ge        [FB + 1];
    logic [TB-1:0] rem_next  [FB + 1];
    logic [FB-1:0] quo_next  [FB + 1];

    logic advance;
    logic accept;

    assign advance = !(valid_reg[FB] && q_full);
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = valid_reg[FB] && !q_full;
    assign q_frac  = sat_reg[FB] ? ONE : {1'b0, quo_reg[FB]};

    always_comb
    begin
        trial[0]    = '0;
        ge[0]       = 1'b0;
        rem_next[0] = '0;
        quo_next[0] = '0;
        for (int k = 1; k <= FB; k++)
        begin
            trial[k]    = {rem_reg[k-1], 1'b0};
            ge[k]       = (trial[k] >= {1'b0, total_reg[k-1]});
            rem_next[k] = ge[k] ? TB'(trial[k] - {1'b0, total_reg[k-1]})
                                : trial[k][TB-1:0];
            quo_next[k] = {quo_reg[k-1][FB-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FB; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= accept;
            for (int k = 1; k <= FB; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // zero lifespan or elapsed at or past lifespan saturates at one
            sat_reg[0]   <= (life_total == '0) || (life_elapsed >= life_total);
            rem_reg[0]   <= life_elapsed;
            total_reg[0] <= life_total;
            quo_reg[0]   <= '0;
            for (int k = 1; k <= FB; k++)
            begin
                sat_reg[k]   <= sat_reg[k-1];
                rem_reg[k]   <= rem_next[k];
                total_reg[k] <= total_reg[k-1];
                quo_reg[k]   <= quo_next[k];
            end
        end
    end

endmodule

// ===== design/lcg_back.sv =====
module lcg_back #(
    parameter int FRACTION_BITS = lcg_pkg::FRACTION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcg_pkg::cfg_t          cfg,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  logic [FRACTION_BITS:0] q_frac,
    output logic                   o_push,
    input  logic                   o_full,
    output lcg_pkg::res_t          o_data
);

    localparam int FB   = FRACTION_BITS;
    localparam int PW   = FB + 4;
    localparam int MW   = FB + lcg_pkg::CH_BITS + 1;
    localparam int CHB  = lcg_pkg::CH_BITS;
    localparam int NCH  = lcg_pkg::NUM_CH;
    localparam int SIB  = lcg_pkg::STOP_IDX_BITS;
    localparam int CB   = lcg_pkg::COUNT_BITS;
    localparam logic [FB:0] ONE  = (FB + 1)'(1) << FB;
    localparam logic [MW-1:0] HALF = MW'(1) << (FB - 1);
    localparam logic [CB-1:0] MAXC = CB'(lcg_pkg::MAX_STOPS);

    function automatic logic [lcg_pkg::STOP_BITS-1:0] stop_sel(
        input lcg_pkg::cfg_t c,
        input logic [SIB-1:0] idx
    );
        logic [lcg_pkg::PAIR_BITS-1:0] word;
        word = c.pair[idx[2:1]];
        if (idx >= SIB'(lcg_pkg::MAX_STOPS))
        begin
            return '0;
        end
        return idx[0] ? word[63:32] : word[31:0];
    endfunction

    logic advance;

    // stage a: index, remainder and stop colors
    logic [CB-1:0]  cnt_eff;
    logic [CB-1:0]  cnt_m1;
    logic [PW-1:0]  prod;
    logic [SIB-1:0] base;
    logic [FB-1:0]  rem;
    logic           cvalid;

    logic                            a_valid_reg;
    logic                            a_cvalid_reg;
    logic [FB-1:0]                   a_rem_reg;
    logic [lcg_pkg::STOP_BITS-1:0]   a_s_reg;
    logic [lcg_pkg::STOP_BITS-1:0]   a_e_reg;

    // stage b: weighted channel products
    logic [FB:0]   wt_s;
    logic [MW-1:0] b_ps_reg [NCH];
    logic [MW-1:0] b_pe_reg [NCH];
    logic          b_valid_reg;
    logic          b_cvalid_reg;

    logic [MW-1:0]  sum     [NCH];
    logic [CHB-1:0] chan    [NCH];

    assign advance = !(b_valid_reg && o_full);
    assign q_pop   = !q_empty && advance;
    assign o_push  = b_valid_reg && !o_full;

    always_comb
    begin
        cnt_eff = (cfg.count > MAXC) ? MAXC : cfg.count;
        cvalid  = (cnt_eff != '0);
        cnt_m1  = cvalid ? cnt_eff - 1'b1 : '0;
        prod    = PW'(q_frac) * PW'(cnt_m1);
        base    = prod[FB +: SIB];
        rem     = prod[FB-1:0];
        // fraction of one lands on the last stop in use
        if (base >= cnt_m1)
        begin
            base = cnt_m1;
            rem  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= q_pop;
            b_valid_reg <= a_valid_reg;
        end
    end

    assign wt_s = ONE - {1'b0, a_rem_reg};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_cvalid_reg <= cvalid;
            a_rem_reg    <= rem;
            a_s_reg      <= cvalid ? stop_sel(cfg, base) : '0;
            a_e_reg      <= cvalid ? stop_sel(cfg, base + 1'b1) : '0;

            b_cvalid_reg <= a_cvalid_reg;
            for (int c = 0; c < NCH; c++)
            begin
                b_ps_reg[c] <= MW'(a_s_reg[c*CHB +: CHB]) * MW'(wt_s);
                b_pe_reg[c] <= MW'(a_e_reg[c*CHB +: CHB]) * MW'(a_rem_reg);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            sum[c]  = b_ps_reg[c] + b_pe_reg[c] + HALF;
            chan[c] = sum[c][FB +: CHB];
        end
        o_data.valid = b_cvalid_reg;
        o_data.red   = chan[0];
        o_data.green = chan[1];
        o_data.blue  = chan[2];
        o_data.alpha = chan[3];
    end

endmodule

// ===== design/lifetime_colour_gradient.sv =====
// lifetime_colour_gradient: maps an item's age to a color on a ramp of
// up to eight evenly spaced rgba stops
// input channel: push with life_elapsed and life_total, taken when full is
// low; one item may enter every cycle
// result channel: the oldest result sits on colour_valid and the channel
// ports while empty is low, and leaves when pop is high
// configuration: cfg_wen writes cfg_data into register cfg_index (0 count,
// 1..4 stop pairs) at the clock edge; only while no items are in flight,
// a rule for the user that the block itself does not enforce
// path: the divider pipeline (one quotient bit per stage), the middle queue,
// the two interpolation stages and the result queue
// throughput: one item per cycle while the result queue does not fill
// reset: all queues empty, every pipeline stage idle, configuration cleared
// when the receiver stalls the result queue fills, then the back stages
// hold, then the middle queue fills, and finally full rises on the input
module lifetime_colour_gradient #(
    parameter int TIME_BITS     = lcg_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = lcg_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = lcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             push,
    output logic                             full,
    input  logic [TIME_BITS-1:0]             life_elapsed,
    input  logic [TIME_BITS-1:0]             life_total,
    // result items
    output logic                             empty,
    input  logic                             pop,
    output logic                             colour_valid,
    output logic [lcg_pkg::CH_BITS-1:0]      red_out,
    output logic [lcg_pkg::CH_BITS-1:0]      green_out,
    output logic [lcg_pkg::CH_BITS-1:0]      blue_out,
    output logic [lcg_pkg::CH_BITS-1:0]      alpha_out,
    // configuration writes
    input  logic                             cfg_wen,
    input  logic [lcg_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [lcg_pkg::PAIR_BITS-1:0]    cfg_data
);

    localparam int FW = FRACTION_BITS + 1;
    localparam int RW = $bits(lcg_pkg::res_t);

    lcg_pkg::cfg_t cfg_reg;

    // front to back fraction queue
    logic          fq_push, fq_full, fq_pop, fq_empty;
    logic [FW-1:0] fq_wdata, fq_rdata;

    // back to result queue
    logic          rq_push, rq_full;
    lcg_pkg::res_t rq_wdata, rq_rdata;
    logic [RW-1:0] rq_rvec;

    // configuration registers, ignored for indexes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                lcg_pkg::REG_COUNT: cfg_reg.count   <= cfg_data[lcg_pkg::COUNT_BITS-1:0];
                lcg_pkg::REG_PAIR0: cfg_reg.pair[0] <= cfg_data;
                lcg_pkg::REG_PAIR1: cfg_reg.pair[1] <= cfg_data;
                lcg_pkg::REG_PAIR2: cfg_reg.pair[2] <= cfg_data;
                lcg_pkg::REG_PAIR3: cfg_reg.pair[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // fraction pipeline: elapsed / total, saturated at one
    lcg_front #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .life_elapsed (life_elapsed),
        .life_total   (life_total),
        .q_push       (fq_push),
        .q_full       (fq_full),
        .q_frac       (fq_wdata)
    );

    lcg_fifo #(
        .WIDTH (FW),
        .DEPTH (QUEUE_DEPTH)
    ) u_frac_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .full  (fq_full),
        .wdata (fq_wdata),
        .pop   (fq_pop),
        .empty (fq_empty),
        .rdata (fq_rdata)
    );

    // interpolation between neighboring stops
    lcg_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (fq_empty),
        .q_pop   (fq_pop),
        .q_frac  (fq_rdata),
        .o_push  (rq_push),
        .o_full  (rq_full),
        .o_data  (rq_wdata)
    );

    lcg_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .full  (rq_full),
        .wdata (rq_wdata),
        .pop   (pop),
        .empty (empty),
        .rdata (rq_rvec)
    );

    assign rq_rdata     = lcg_pkg::res_t'(rq_rvec);
    assign colour_valid = rq_rdata.valid;
    assign red_out      = rq_rdata.red;
    assign green_out    = rq_rdata.green;
    assign blue_out     = rq_rdata.blue;
    assign alpha_out    = rq_rdata.alpha;

endmodule
